### rtl/pfe_pkg.sv
package pfe_pkg;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_MOD,
    OP_POW
  } op_e;

  // request to the shared arithmetic unit
  typedef struct packed {
    logic        start;
    op_e         op;
    logic [31:0] lhs;
    logic [31:0] rhs;
  } alu_req_t;

  // answer from the shared arithmetic unit
  typedef struct packed {
    logic        done;
    logic [31:0] value;
    logic        err;
  } alu_rsp_t;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [31:0] OneQ    = 32'h0001_0000;
  localparam logic [31:0] MinusOneQ = 32'hFFFF_0000;
  localparam logic [31:0] MaxQ    = 32'h7FFF_FFFF;
  localparam logic [31:0] MinQ    = 32'h8000_0000;

  typedef enum logic [3:0] {
    A_IDLE,
    A_MUL,
    A_MULSAT,
    A_DIVSETUP,
    A_DIV,
    A_DIVFIN,
    A_POWMUL,
    A_POWMSAT,
    A_DONE
  } alu_state_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POPR,
    S_POPL,
    S_WAIT,
    S_PUSH,
    S_LAST,
    S_OUT
  } seq_state_e;

  // saturate a 64-bit signed value to 32 bits
  function automatic logic [32:0] sat64(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) r = {1'b1, MaxQ};
    else if (v < -64'sh0000_0000_8000_0000) r = {1'b1, MinQ};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

  // truncate Q16.16 toward zero to an integer
  function automatic logic signed [15:0] qtrunc(input logic signed [31:0] v);
    logic [31:0] m;
    logic [15:0] t;
    m = v[31] ? (~v + 32'd1) : v;
    t = m[31:16];
    return v[31] ? $signed(~t + 16'd1) : $signed(t);
  endfunction

endpackage

### rtl/pfe_alu.sv
module pfe_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfe_pkg::alu_req_t req_i,
  output pfe_pkg::alu_rsp_t rsp_o
);

  pfe_pkg::alu_state_e state_q, state_d;
  pfe_pkg::op_e op_q, op_d;
  logic [31:0] lhs_q, lhs_d;
  logic [31:0] rhs_q, rhs_d;
  logic [31:0] acc_q, acc_d;
  logic signed [63:0] prod_q, prod_d;
  logic [63:0] num_q, num_d;     // dividend magnitude, shifts out
  logic [32:0] den_q, den_d;
  logic [32:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [15:0] pcnt_q, pcnt_d;   // remaining power steps
  logic        neg_q, neg_d;
  logic        pinv_q, pinv_d;   // power with negative exponent
  logic        err_q, err_d;
  logic [31:0] res_q, res_d;

  logic signed [63:0] mprod;
  logic [31:0] mul_a, mul_b;
  logic [32:0] sat;
  logic [32:0] rtry;
  logic signed [15:0] ti_l, ti_r;
  logic [15:0] mag_l, mag_r;
  logic signed [64:0] sq;
  logic [63:0] pm;

  // one multiplier, shared by multiply and power steps
  assign mul_a = (state_q == pfe_pkg::A_POWMUL) ? acc_q : lhs_q;
  assign mul_b = (state_q == pfe_pkg::A_POWMUL) ? lhs_q : rhs_q;
  assign mprod = $signed(mul_a) * $signed(mul_b);
  assign ti_l  = pfe_pkg::qtrunc(lhs_q);
  assign ti_r  = pfe_pkg::qtrunc(rhs_q);
  assign mag_l = ti_l[15] ? (~ti_l + 16'd1) : ti_l;
  assign mag_r = ti_r[15] ? (~ti_r + 16'd1) : ti_r;
  assign rtry  = {rem_q[31:0], num_q[63]} - den_q;
  assign sq    = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign pm    = prod_q[63] ? ((~prod_q + 64'd1) + 64'd65535) : prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfe_pkg::A_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; lhs_q <= lhs_d; rhs_q <= rhs_d; acc_q <= acc_d;
    prod_q <= prod_d; num_q <= num_d; den_q <= den_d; rem_q <= rem_d;
    quo_q <= quo_d; cnt_q <= cnt_d; pcnt_q <= pcnt_d; neg_q <= neg_d;
    pinv_q <= pinv_d; err_q <= err_d; res_q <= res_d;
  end

  // sequencer of the shared multiply and divide steps
  always_comb begin
    state_d = state_q; op_d = op_q; lhs_d = lhs_q; rhs_d = rhs_q; acc_d = acc_q;
    prod_d = prod_q; num_d = num_q; den_d = den_q; rem_d = rem_q; quo_d = quo_q;
    cnt_d = cnt_q; pcnt_d = pcnt_q; neg_d = neg_q; pinv_d = pinv_q;
    err_d = err_q; res_d = res_q;
    sat = '0;
    rsp_o.done  = 1'b0;
    rsp_o.value = res_q;
    rsp_o.err   = err_q;
    case (state_q)
      pfe_pkg::A_IDLE: begin
        if (req_i.start) begin
          op_d = req_i.op; lhs_d = req_i.lhs; rhs_d = req_i.rhs; err_d = 1'b0;
          pinv_d = 1'b0;
          case (req_i.op)
            pfe_pkg::OP_ADD: begin
              sat = pfe_pkg::sat64(64'($signed(req_i.lhs)) + 64'($signed(req_i.rhs)));
              res_d = sat[31:0]; err_d = sat[32]; state_d = pfe_pkg::A_DONE;
            end
            pfe_pkg::OP_SUB: begin
              sat = pfe_pkg::sat64(64'($signed(req_i.lhs)) - 64'($signed(req_i.rhs)));
              res_d = sat[31:0]; err_d = sat[32]; state_d = pfe_pkg::A_DONE;
            end
            pfe_pkg::OP_MUL: state_d = pfe_pkg::A_MUL;
            pfe_pkg::OP_DIV: state_d = pfe_pkg::A_DIVSETUP;
            pfe_pkg::OP_MOD: state_d = pfe_pkg::A_DIVSETUP;
            default: begin
              acc_d = pfe_pkg::OneQ;
              state_d = pfe_pkg::A_POWMUL;
            end
          endcase
        end
      end
      pfe_pkg::A_MUL: begin
        prod_d = mprod;
        state_d = pfe_pkg::A_MULSAT;
      end
      pfe_pkg::A_MULSAT: begin
        // floor of product / 2^16, then saturate
        sat = pfe_pkg::sat64(prod_q[63] ? -$signed({16'd0, pm[63:16]})
                                        : $signed({16'd0, pm[63:16]}));
        res_d = sat[31:0]; err_d = err_q | sat[32];
        state_d = pfe_pkg::A_DONE;
      end
      pfe_pkg::A_DIVSETUP: begin
        if (op_q == pfe_pkg::OP_MOD) begin
          if (ti_r == 16'sd0) begin
            res_d = lhs_q[31] ? pfe_pkg::MinQ : pfe_pkg::MaxQ;
            err_d = 1'b1;
            state_d = pfe_pkg::A_DONE;
          end else begin
            // integer remainder through the same divider, sign of the left side
            num_d = {48'd0, mag_l};
            den_d = {17'd0, mag_r};
            neg_d = ti_l[15];
            rem_d = '0; quo_d = '0; cnt_d = 7'd64;
            state_d = pfe_pkg::A_DIV;
          end
        end else if (rhs_q == '0) begin
          res_d = lhs_q[31] ? pfe_pkg::MinQ : pfe_pkg::MaxQ;
          err_d = 1'b1;
          state_d = pfe_pkg::A_DONE;
        end else begin
          num_d = {16'd0, (lhs_q[31] ? (~lhs_q + 32'd1) : lhs_q), 16'd0};
          den_d = {1'b0, (rhs_q[31] ? (~rhs_q + 32'd1) : rhs_q)};
          neg_d = lhs_q[31] ^ rhs_q[31];
          rem_d = '0; quo_d = '0; cnt_d = 7'd64;
          state_d = pfe_pkg::A_DIV;
        end
      end
      pfe_pkg::A_DIV: begin
        // one restoring step per cycle
        if (!rtry[32]) begin
          rem_d = rtry; quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = {rem_q[31:0], num_q[63]}; quo_d = {quo_q[62:0], 1'b0};
        end
        num_d = {num_q[62:0], 1'b0};
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) state_d = pfe_pkg::A_DIVFIN;
      end
      pfe_pkg::A_DIVFIN: begin
        if (op_q == pfe_pkg::OP_MOD) begin
          res_d = neg_q ? (~{rem_q[15:0], 16'd0} + 32'd1) : {rem_q[15:0], 16'd0};
        end else begin
          sat = pfe_pkg::sat64(sq[63:0]);
          res_d = sat[31:0]; err_d = err_q | sat[32];
        end
        state_d = pfe_pkg::A_DONE;
      end
      pfe_pkg::A_POWMUL: begin
        // set up step count on first entry via op code
        if (op_q == pfe_pkg::OP_POW) begin
          op_d = pfe_pkg::OP_MUL;
          pinv_d = ti_r[15];
          pcnt_d = mag_r;
        end else if (pcnt_q == '0) begin
          if (pinv_q) begin
            lhs_d = pfe_pkg::OneQ; rhs_d = acc_q; op_d = pfe_pkg::OP_DIV;
            state_d = pfe_pkg::A_DIVSETUP;
          end else begin
            res_d = acc_q;
            state_d = pfe_pkg::A_DONE;
          end
        end else begin
          prod_d = mprod;
          pcnt_d = pcnt_q - 16'd1;
          state_d = pfe_pkg::A_POWMSAT;
        end
      end
      pfe_pkg::A_POWMSAT: begin
        sat = pfe_pkg::sat64(prod_q[63] ? -$signed({16'd0, pm[63:16]})
                                        : $signed({16'd0, pm[63:16]}));
        acc_d = sat[31:0]; err_d = err_q | sat[32];
        state_d = pfe_pkg::A_POWMUL;
      end
      pfe_pkg::A_DONE: begin
        rsp_o.done = 1'b1;
        state_d = pfe_pkg::A_IDLE;
      end
      default: state_d = pfe_pkg::A_IDLE;
    endcase
  end

endmodule

### rtl/postfix_expression_evaluator_core.sv
// Postfix evaluator: takes one ASCII character per item and gives one Q16.16
// result after the item marked last. An operator pops its right and then its
// left operand and waits for the arithmetic unit: divide and modulo run one
// quotient bit per cycle over 64 bits unless the divisor is zero, and power
// runs one multiply per unit of |exponent| (up to 32768 steps) plus a divide
// for a negative exponent. The last item waits for the result to be taken.
// All arithmetic shares one sequenced multiply/divide unit.
module postfix_expression_evaluator_core #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] result_value_o,
  output logic        overflow_seen_o,
  output logic        underflow_seen_o,
  output logic        arith_error_o
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] Full = CW'(STACK_DEPTH);

  pfe_pkg::seq_state_e state_q, state_d;
  logic [31:0] stack_q [STACK_DEPTH];
  logic [CW-1:0] cnt_q, cnt_d;
  logic [3:0] pdig_q, pdig_d;
  logic pval_q, pval_d;
  logic [2:0] flags_q, flags_d;
  logic [7:0] ch_q, ch_d;
  logic last_q, last_d;
  logic [31:0] r_q, r_d, l_q, l_d, pv_q, pv_d;
  logic do_push;
  logic [31:0] push_val;
  logic [31:0] top_q;
  pfe_pkg::alu_req_t req;
  pfe_pkg::alu_rsp_t rsp;
  pfe_pkg::op_e op;
  logic is_dig, is_op;
  logic [3:0] dv;
  logic [CW-1:0] cm1;
  logic [CW-1:0] nm1;
  logic [AW-1:0] rd_addr;
  logic [7:0] two;

  pfe_alu u_alu (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_o(rsp));

  assign cm1 = cnt_q - CW'(1);
  assign nm1 = cnt_d - CW'(1);
  assign rd_addr = nm1[AW-1:0];
  assign is_dig = (ch_q >= pfe_pkg::ChZero) && (ch_q <= pfe_pkg::ChNine);
  assign dv = 4'(ch_q - pfe_pkg::ChZero);
  assign two = {1'b0, pdig_q, 3'b0} + {3'b0, pdig_q, 1'b0} + {4'b0, dv};

  always_comb begin
    is_op = 1'b1;
    case (ch_q)
      pfe_pkg::ChPlus:  op = pfe_pkg::OP_ADD;
      pfe_pkg::ChMinus: op = pfe_pkg::OP_SUB;
      pfe_pkg::ChStar:  op = pfe_pkg::OP_MUL;
      pfe_pkg::ChSlash: op = pfe_pkg::OP_DIV;
      pfe_pkg::ChPct:   op = pfe_pkg::OP_MOD;
      pfe_pkg::ChCaret, pfe_pkg::ChDollar: op = pfe_pkg::OP_POW;
      default: begin op = pfe_pkg::OP_ADD; is_op = 1'b0; end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfe_pkg::S_IDLE;
      cnt_q <= '0; pdig_q <= '0; pval_q <= 1'b0; flags_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d; pdig_q <= pdig_d; pval_q <= pval_d; flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= ch_d; last_q <= last_d; r_q <= r_d; l_q <= l_d; pv_q <= pv_d;
  end

  // stack memory, top entry read into a register ahead of its use
  always_ff @(posedge clk_i) begin
    if (do_push && cnt_q < Full) begin
      stack_q[cnt_q[AW-1:0]] <= push_val;
      top_q <= push_val;
    end else begin
      top_q <= stack_q[rd_addr];
    end
  end

  assign in_ready_o = (state_q == pfe_pkg::S_IDLE);
  assign out_valid_o = (state_q == pfe_pkg::S_OUT);
  assign result_value_o = pv_q;
  assign overflow_seen_o = flags_q[0];
  assign underflow_seen_o = flags_q[1];
  assign arith_error_o = flags_q[2];

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; pdig_d = pdig_q; pval_d = pval_q;
    flags_d = flags_q; ch_d = ch_q; last_d = last_q; r_d = r_q; l_d = l_q;
    pv_d = pv_q;
    do_push = 1'b0; push_val = '0;
    req.start = 1'b0; req.op = op; req.lhs = l_q; req.rhs = r_q;
    case (state_q)
      pfe_pkg::S_IDLE: begin
        if (in_valid_i) begin
          ch_d = char_code_i; last_d = last_char_i;
          state_d = pfe_pkg::S_POPR;
        end
      end
      pfe_pkg::S_POPR: begin
        // digit and space handling, or the top read before an operator's first pop
        state_d = last_q ? pfe_pkg::S_LAST : pfe_pkg::S_IDLE;
        if (pval_q && is_dig) begin
          pval_d = 1'b0; do_push = 1'b1;
          push_val = {8'd0, two, 16'd0};
        end else begin
          if (pval_q && ch_q == pfe_pkg::ChSpace) begin
            do_push = 1'b1; push_val = {12'd0, pdig_q, 16'd0};
          end
          pval_d = 1'b0;
          if (is_dig) begin
            pdig_d = dv; pval_d = 1'b1;
          end else if (is_op) begin
            state_d = pfe_pkg::S_POPL;
          end
        end
        if (do_push) begin
          if (cnt_q < Full) cnt_d = cnt_q + CW'(1);
          else flags_d[0] = 1'b1;
        end
      end
      pfe_pkg::S_POPL: begin
        // pops take effect in POPL and WAIT; right comes first
        if (cnt_q == '0) begin
          r_d = pfe_pkg::MinusOneQ; flags_d[1] = 1'b1;
        end else begin
          r_d = top_q; cnt_d = cm1;
        end
        state_d = pfe_pkg::S_WAIT;
        ch_d = ch_q;
        last_d = last_q;
        l_d = 32'd0;
        pv_d = pv_q;
        // hold the pending digit flag
        pval_d = pval_q;
      end
      pfe_pkg::S_WAIT: begin
        // left pop, then start the arithmetic unit
        if (cnt_q == '0) begin
          l_d = pfe_pkg::MinusOneQ; flags_d[1] = 1'b1;
        end else begin
          l_d = top_q; cnt_d = cm1;
        end
        state_d = pfe_pkg::S_PUSH;
      end
      pfe_pkg::S_PUSH: begin
        // start on entry, then clear the character as a started mark
        req.start = (ch_q != 8'd0);
        ch_d = 8'd0;
        if (ch_q == 8'd0 && rsp.done) begin
          do_push = 1'b1; push_val = rsp.value;
          if (rsp.err) flags_d[2] = 1'b1;
          if (cnt_q < Full) cnt_d = cnt_q + CW'(1);
          else flags_d[0] = 1'b1;
          state_d = last_q ? pfe_pkg::S_LAST : pfe_pkg::S_IDLE;
        end
      end
      pfe_pkg::S_LAST: begin
        if (cnt_q == '0) begin
          pv_d = pfe_pkg::MinusOneQ; flags_d[1] = 1'b1;
        end else begin
          pv_d = top_q;
        end
        cnt_d = '0;
        state_d = pfe_pkg::S_OUT;
      end
      pfe_pkg::S_OUT: begin
        if (out_ready_i) begin
          flags_d = '0; pdig_d = '0; pval_d = 1'b0;
          state_d = pfe_pkg::S_IDLE;
        end
      end
      default: state_d = pfe_pkg::S_IDLE;
    endcase
  end

  // checks
  a_no_ready_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready during output");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full) else $error("stack count beyond depth");
  a_out_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == pfe_pkg::S_LAST))
    else $error("result without last item");

endmodule
